### rtl/core/gpio_prb_pkg.sv
// shared types and constants of the gpio port register block
`timescale 1ns / 1ps

package gpio_prb_pkg;

  // bus access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // register map
  localparam logic [2:0] REG_CRL    = 3'd0;
  localparam logic [2:0] REG_CRH    = 3'd1;
  localparam logic [2:0] REG_IDR    = 3'd2;
  localparam logic [2:0] REG_ODR    = 3'd3;
  localparam logic [2:0] REG_BSRR   = 3'd4;
  localparam logic [2:0] REG_BRR    = 3'd5;
  localparam logic [2:0] REG_LCKR   = 3'd6;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam logic [31:0] CFG_RESET   = 32'h4444_4444;
  localparam int          LCK_KEY_POS = 16;

  // one bus access
  typedef struct packed {
    logic        op;
    logic [2:0]  idx;
    logic [31:0] data;
    logic [15:0] pins;
  } req_t;

  // lock sequencer status toward the register file
  typedef struct packed {
    logic [15:0] frozen;   // pins whose config nibbles are locked
    logic [31:0] rd_word;  // lckr read value
    logic        set_now;  // lock active before this request
    logic        set_nxt;  // lock active after this request
  } lock_stat_t;

  // one result
  typedef struct packed {
    logic        lock_active;
    logic [31:0] config_high;
    logic [31:0] config_low;
    logic [15:0] output_latch;
    logic [31:0] read_data;
  } res_t;

endpackage

### rtl/core/gpio_prb_lock.sv
// lock key sequencer and lock bits of the gpio port
`timescale 1ns / 1ps

module gpio_prb_lock #(
  parameter int PIN_COUNT = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  gpio_prb_pkg::req_t      req,
  output gpio_prb_pkg::lock_stat_t stat
);

  localparam logic [15:0] PIN_MASK = 16'((1 << PIN_COUNT) - 1);

  typedef enum logic [2:0] {
    LK_IDLE,
    LK_STEP1,
    LK_STEP2,
    LK_STEP3,
    LK_DONE
  } lock_state_t;

  lock_state_t state_r, state_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] wr_bits;
  logic        key;
  logic        same;
  logic        locked;

  assign locked  = (state_r == LK_DONE);
  assign wr_bits = req.data[15:0] & PIN_MASK;
  assign key     = req.data[gpio_prb_pkg::LCK_KEY_POS];
  assign same    = (wr_bits == bits_r);

  always_comb begin
    state_nxt = state_r;
    bits_nxt  = bits_r;
    if (fire && req.idx == gpio_prb_pkg::REG_LCKR && !locked) begin
      if (req.op == gpio_prb_pkg::OP_WRITE) begin
        bits_nxt  = wr_bits;
        // a write that breaks the key restarts the sequence with itself if its key bit is set, else goes idle
        state_nxt = key ? LK_STEP1 : LK_IDLE;
        case (state_r)
          LK_STEP1: if (!key && same) state_nxt = LK_STEP2;
          LK_STEP2: if (key && same)  state_nxt = LK_STEP3;
          default: ;
        endcase
      end else begin
        state_nxt = (state_r == LK_STEP3) ? LK_DONE : LK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LK_IDLE;
      bits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      bits_r  <= bits_nxt;
    end
  end

  assign stat.frozen  = locked ? bits_r : '0;
  assign stat.rd_word = {15'd0, locked, bits_r};
  assign stat.set_now = locked;
  assign stat.set_nxt = (state_nxt == LK_DONE);

endmodule

### rtl/core/gpio_prb_regs.sv
// configuration words, output latch and read mux of the gpio port
`timescale 1ns / 1ps

module gpio_prb_regs #(
  parameter int PIN_COUNT = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  gpio_prb_pkg::req_t       req,
  input  gpio_prb_pkg::lock_stat_t stat,
  output gpio_prb_pkg::res_t       res
);

  localparam logic [15:0] PIN_MASK = 16'((1 << PIN_COUNT) - 1);

  logic [31:0] cfg_lo_r, cfg_lo_nxt;
  logic [31:0] cfg_hi_r, cfg_hi_nxt;
  logic [15:0] odr_r, odr_nxt;
  logic [31:0] wm_lo, wm_hi;
  logic [31:0] rd;

  // nibble write masks: present and not frozen
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      wm_lo[i*4 +: 4] = (PIN_MASK[i] && !stat.frozen[i]) ? 4'hF : 4'h0;
      wm_hi[i*4 +: 4] = (PIN_MASK[i+8] && !stat.frozen[i+8]) ? 4'hF : 4'h0;
    end
  end

  always_comb begin
    cfg_lo_nxt = cfg_lo_r;
    cfg_hi_nxt = cfg_hi_r;
    odr_nxt    = odr_r;
    rd         = '0;
    if (req.op == gpio_prb_pkg::OP_WRITE) begin
      case (req.idx)
        gpio_prb_pkg::REG_CRL:  cfg_lo_nxt = (cfg_lo_r & ~wm_lo) | (req.data & wm_lo);
        gpio_prb_pkg::REG_CRH:  cfg_hi_nxt = (cfg_hi_r & ~wm_hi) | (req.data & wm_hi);
        gpio_prb_pkg::REG_ODR:  odr_nxt = req.data[15:0] & PIN_MASK;
        // set wins over clear
        gpio_prb_pkg::REG_BSRR: odr_nxt = ((odr_r & ~req.data[31:16]) | req.data[15:0])
                                          & PIN_MASK;
        gpio_prb_pkg::REG_BRR:  odr_nxt = odr_r & ~req.data[15:0] & PIN_MASK;
        default: ;
      endcase
    end else begin
      case (req.idx)
        gpio_prb_pkg::REG_CRL:  rd = cfg_lo_r;
        gpio_prb_pkg::REG_CRH:  rd = cfg_hi_r;
        gpio_prb_pkg::REG_IDR:  rd = {16'd0, req.pins & PIN_MASK};
        gpio_prb_pkg::REG_ODR:  rd = {16'd0, odr_r};
        gpio_prb_pkg::REG_LCKR: rd = stat.rd_word;
        default:                rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lo_r <= gpio_prb_pkg::CFG_RESET;
      cfg_hi_r <= gpio_prb_pkg::CFG_RESET;
      odr_r    <= '0;
    end else if (fire) begin
      cfg_lo_r <= cfg_lo_nxt;
      cfg_hi_r <= cfg_hi_nxt;
      odr_r    <= odr_nxt;
    end
  end

  assign res.read_data    = rd;
  assign res.output_latch = odr_nxt;
  assign res.config_low   = cfg_lo_nxt;
  assign res.config_high  = cfg_hi_nxt;
  assign res.lock_active  = stat.set_nxt;

endmodule

### rtl/core/gpio_port_register_block_unit.sv
// top level of the gpio port register block
//
// usage:
// - in_ channel carries one bus request per item: tuser holds the access kind
//   (read or write) and the register index, tdata the write word and the
//   sampled pin levels
// - out_ channel returns one result per request: read data plus a snapshot of
//   the output latch, both configuration words and the lock flag after the
//   access
// - a request sits in the input register, then its access is applied to the
//   port state and the result lands in the output register, which drives
//   out_tvalid
// - throughput is one request per cycle unless the receiver stalls; all state
//   updates are a single pass of logic between the input and result registers
// - when the receiver stalls, the result holds in the output register, one more
//   request waits in the input register, and only then in_tready drops
// - reset clears the valid flags of both pipeline registers, loads 0x44444444
//   into the configuration words, clears the output latch and lock bits and
//   returns the lock key sequencer to idle
`timescale 1ns / 1ps

module gpio_port_register_block_unit #(
  parameter int PIN_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // write_data[31:0], pin_levels[47:32]
  input  logic [3:0]   in_tuser,   // operation[0], register_index[3:1]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata   // read_data[31:0], output_latch[47:32],
                                   // config_low[79:48], config_high[111:80],
                                   // lock_active[112], zero fill above
);

  localparam logic [15:0] PIN_MASK = 16'((1 << PIN_COUNT) - 1);

  gpio_prb_pkg::req_t       req_r;
  gpio_prb_pkg::res_t       res_r;
  gpio_prb_pkg::res_t       res_nxt;
  gpio_prb_pkg::lock_stat_t stat;
  logic                     in_v_r;
  logic                     out_v_r;
  logic                     fire;

  // request moves from input register into result register
  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.op   <= in_tuser[0];
      req_r.idx  <= in_tuser[3:1];
      req_r.data <= in_tdata[31:0];
      req_r.pins <= in_tdata[47:32];
    end
  end

  // lock key sequencer
  gpio_prb_lock #(
    .PIN_COUNT(PIN_COUNT)
  ) u_lock (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .req  (req_r),
    .stat (stat)
  );

  // port state and read mux
  gpio_prb_regs #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regs (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .req  (req_r),
    .stat (stat),
    .res  (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, res_r.lock_active, res_r.config_high, res_r.config_low,
                       res_r.output_latch, res_r.read_data};

  // once locked, the lock stays until reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.set_now |=> stat.set_now)
    else $error("lock dropped without reset");

  // input side only stalls when both registers are full and the receiver stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_v_r && out_v_r && !out_tready))
    else $error("input stalled without a full pipeline");

  // absent pins never drive an output bit
  a_absent_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((res_r.output_latch & ~PIN_MASK) == 16'd0))
    else $error("output latch bit set on an absent pin");

endmodule
